### rtl/core/rlf_pkg.sv
// ----------------------------------------------------------------------------
// rlf_pkg
// Shared types and constants for the RGB LED fade and breathing PWM block.
// ----------------------------------------------------------------------------
package rlf_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_TICKS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HUE_PHASE_STEPS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BREATH_PEAK     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DWELL_STEPS     = 3'd4;

    // Register reset values
    localparam logic [7:0] RST_PWM_PERIOD      = 8'd100;
    localparam logic [7:0] RST_STEP_TICKS      = 8'd255;
    localparam logic [6:0] RST_HUE_PHASE_STEPS = 7'd30;
    localparam logic [6:0] RST_BREATH_PEAK     = 7'd30;
    localparam logic [3:0] RST_DWELL_STEPS     = 4'd3;

    // Modes
    localparam logic [3:0] MODE_HUE    = 4'd1;
    localparam logic [3:0] MODE_LAST   = 4'd8;
    localparam logic [3:0] MODE_OFFSET = 4'd6;

    // Channel positions in the LED vector
    localparam int unsigned CH_GREEN = 0;
    localparam int unsigned CH_RED   = 1;
    localparam int unsigned CH_BLUE  = 2;
    localparam int unsigned NUM_CH   = 3;

    typedef struct packed {
        logic       green_on;
        logic       red_on;
        logic       blue_on;
        logic [3:0] mode;
    } t_result;

endpackage

### rtl/core/rgb_led_fade_pwm_controller.sv
// ----------------------------------------------------------------------------
// rgb_led_fade_pwm_controller
// PWM tick engine: button mode select, hue fade and breathing duty, LED PWM.
// ----------------------------------------------------------------------------
// Each accepted request's result is registered into the output buffer.
// Throughput: one request per cycle while the buffer has space; all state updates
// settle in one pass of adds and compares. A two-entry output buffer keeps
// requests flowing while a result waits. Synchronous active-low reset restores
// config and run state, mode 1, red duty at reset period, and empties the output.
module rgb_led_fade_pwm_controller (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rlf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rlf_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_button_pressed,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_green_on,
    output logic                             o_red_on,
    output logic                             o_blue_on,
    output logic [3:0]                       o_mode
);

    // Configuration
    logic [7:0] r_pwm_period;
    logic [7:0] r_step_ticks;
    logic [6:0] r_hue_phase_steps;
    logic [6:0] r_breath_peak;
    logic [3:0] r_dwell_steps;

    // Run state
    logic [7:0] r_pwm_count  [rlf_pkg::NUM_CH];
    logic [7:0] n_pwm_count  [rlf_pkg::NUM_CH];
    logic [7:0] r_duty       [rlf_pkg::NUM_CH];
    logic [7:0] n_duty       [rlf_pkg::NUM_CH];
    logic [7:0] r_hue_step_count;
    logic [7:0] n_hue_step_count;
    logic [7:0] r_hue_angle;
    logic [7:0] n_hue_angle;
    logic [3:0] r_mode;
    logic [3:0] n_mode;
    logic [7:0] r_breath_pwm_count;
    logic [7:0] n_breath_pwm_count;
    logic [7:0] r_breath_step_count;
    logic [7:0] n_breath_step_count;
    logic [7:0] r_breath_duty;
    logic [7:0] n_breath_duty;
    logic [3:0] r_dwell_count;
    logic [3:0] n_dwell_count;
    logic       r_breath_rising;
    logic       n_breath_rising;
    logic [2:0] r_led_lit;
    logic [2:0] n_led_lit;
    logic       r_button_held;
    logic       n_button_held;

    logic             in_fire;
    logic             buf_space;
    rlf_pkg::t_result result;

    // Hue and breathing step helpers
    logic [8:0] phase_2x;
    logic [8:0] phase_3x;
    logic [7:0] angle_inc;
    logic [7:0] hstep_inc;
    logic [7:0] bstep_inc;
    logic [8:0] bduty_inc;
    logic [3:0] dwell_inc;
    logic [3:0] mode_sum;

    assign in_fire    = i_in_valid && buf_space;
    assign o_in_ready = buf_space;

    assign phase_2x  = {1'b0, r_hue_phase_steps, 1'b0};
    assign phase_3x  = phase_2x + {2'b00, r_hue_phase_steps};
    assign angle_inc = r_hue_angle + 8'd1;
    assign hstep_inc = r_hue_step_count + 8'd1;
    assign bstep_inc = r_breath_step_count + 8'd1;
    assign bduty_inc = {1'b0, r_breath_duty} + 9'd1;
    assign dwell_inc = r_dwell_count + 4'd1;
    assign mode_sum  = r_mode + rlf_pkg::MODE_OFFSET;

    always_comb begin
        n_pwm_count         = r_pwm_count;
        n_duty              = r_duty;
        n_hue_step_count    = r_hue_step_count;
        n_hue_angle         = r_hue_angle;
        n_mode              = r_mode;
        n_breath_pwm_count  = r_breath_pwm_count;
        n_breath_step_count = r_breath_step_count;
        n_breath_duty       = r_breath_duty;
        n_dwell_count       = r_dwell_count;
        n_breath_rising     = r_breath_rising;
        n_led_lit           = r_led_lit;
        n_button_held       = r_button_held;

        if (i_button_pressed) begin
            if (!r_button_held) begin
                n_button_held = 1'b1;
                n_mode = (r_mode == rlf_pkg::MODE_LAST) ? rlf_pkg::MODE_HUE
                                                        : r_mode + 4'd1;
                for (int i = 0; i < rlf_pkg::NUM_CH; i++) begin
                    n_pwm_count[i] = 8'd0;
                    n_duty[i]      = 8'd0;
                end
                if (n_mode == rlf_pkg::MODE_HUE) begin
                    n_duty[rlf_pkg::CH_RED] = r_pwm_period;
                end
                n_hue_step_count    = 8'd0;
                n_hue_angle         = 8'd0;
                n_breath_pwm_count  = 8'd0;
                n_breath_step_count = 8'd0;
                n_breath_duty       = 8'd0;
                n_dwell_count       = 4'd0;
                n_breath_rising     = 1'b1;
            end
        end else begin
            n_button_held = 1'b0;
            if (r_mode == rlf_pkg::MODE_HUE) begin
                for (int i = 0; i < rlf_pkg::NUM_CH; i++) begin
                    n_pwm_count[i] = r_pwm_count[i] + 8'd1;
                end
                n_hue_step_count = hstep_inc;
                if (hstep_inc == r_step_ticks) begin
                    n_hue_step_count = 8'd0;
                    n_hue_angle = ({1'b0, angle_inc} > phase_3x) ? 8'd0 : angle_inc;
                    if (n_hue_angle == 8'd0) begin
                        // angle wrapped: duties hold
                    end else if (n_hue_angle <= {1'b0, r_hue_phase_steps}) begin
                        if (r_duty[rlf_pkg::CH_GREEN] != 8'hFF)
                            n_duty[rlf_pkg::CH_GREEN] = r_duty[rlf_pkg::CH_GREEN] + 8'd1;
                        if (r_duty[rlf_pkg::CH_RED] != 8'd0)
                            n_duty[rlf_pkg::CH_RED] = r_duty[rlf_pkg::CH_RED] - 8'd1;
                        n_duty[rlf_pkg::CH_BLUE] = 8'd0;
                    end else if ({1'b0, n_hue_angle} <= phase_2x) begin
                        if (r_duty[rlf_pkg::CH_GREEN] != 8'd0)
                            n_duty[rlf_pkg::CH_GREEN] = r_duty[rlf_pkg::CH_GREEN] - 8'd1;
                        n_duty[rlf_pkg::CH_RED] = 8'd0;
                        if (r_duty[rlf_pkg::CH_BLUE] != 8'hFF)
                            n_duty[rlf_pkg::CH_BLUE] = r_duty[rlf_pkg::CH_BLUE] + 8'd1;
                    end else begin
                        n_duty[rlf_pkg::CH_GREEN] = 8'd0;
                        if (r_duty[rlf_pkg::CH_RED] != 8'hFF)
                            n_duty[rlf_pkg::CH_RED] = r_duty[rlf_pkg::CH_RED] + 8'd1;
                        if (r_duty[rlf_pkg::CH_BLUE] != 8'd0)
                            n_duty[rlf_pkg::CH_BLUE] = r_duty[rlf_pkg::CH_BLUE] - 8'd1;
                    end
                end
                for (int i = 0; i < rlf_pkg::NUM_CH; i++) begin
                    if (n_pwm_count[i] == r_pwm_period) begin
                        n_pwm_count[i] = 8'd0;
                        if (n_duty[i] != 8'd0) n_led_lit[i] = 1'b1;
                    end else if (n_pwm_count[i] != 8'd0 && n_pwm_count[i] < r_pwm_period) begin
                        if (n_pwm_count[i] >= n_duty[i]) n_led_lit[i] = 1'b0;
                    end
                end
            end else begin
                n_breath_pwm_count  = r_breath_pwm_count + 8'd1;
                n_breath_step_count = bstep_inc;
                if (bstep_inc >= r_step_ticks) begin
                    n_breath_step_count = 8'd0;
                    if (r_breath_rising) begin
                        if (bduty_inc > {2'b00, r_breath_peak}) begin
                            n_breath_duty   = {1'b0, r_breath_peak};
                            n_breath_rising = 1'b0;
                        end else begin
                            n_breath_duty = bduty_inc[7:0];
                        end
                    end else if (r_breath_duty == 8'd0) begin
                        n_dwell_count = dwell_inc;
                        if (dwell_inc == r_dwell_steps) begin
                            n_dwell_count   = 4'd0;
                            n_breath_rising = 1'b1;
                        end
                    end else begin
                        n_breath_duty = r_breath_duty - 8'd1;
                    end
                end
                if (n_breath_pwm_count == r_pwm_period) begin
                    n_breath_pwm_count = 8'd0;
                    if (n_breath_duty != 8'd0) begin
                        // lit channels: bits of mode+6 that are clear
                        for (int i = 0; i < rlf_pkg::NUM_CH; i++) begin
                            if (!mode_sum[i]) n_led_lit[i] = 1'b1;
                        end
                    end
                end else if (n_breath_pwm_count != 8'd0
                             && n_breath_pwm_count < r_pwm_period) begin
                    if (n_breath_pwm_count >= n_breath_duty) n_led_lit = 3'b000;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_period      <= rlf_pkg::RST_PWM_PERIOD;
            r_step_ticks      <= rlf_pkg::RST_STEP_TICKS;
            r_hue_phase_steps <= rlf_pkg::RST_HUE_PHASE_STEPS;
            r_breath_peak     <= rlf_pkg::RST_BREATH_PEAK;
            r_dwell_steps     <= rlf_pkg::RST_DWELL_STEPS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rlf_pkg::REG_PWM_PERIOD:      r_pwm_period      <= i_cfg_wdata;
                rlf_pkg::REG_STEP_TICKS:      r_step_ticks      <= i_cfg_wdata;
                rlf_pkg::REG_HUE_PHASE_STEPS: r_hue_phase_steps <= i_cfg_wdata[6:0];
                rlf_pkg::REG_BREATH_PEAK:     r_breath_peak     <= i_cfg_wdata[6:0];
                rlf_pkg::REG_DWELL_STEPS:     r_dwell_steps     <= i_cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < rlf_pkg::NUM_CH; i++) begin
                r_pwm_count[i] <= 8'd0;
                r_duty[i]      <= 8'd0;
            end
            r_duty[rlf_pkg::CH_RED] <= rlf_pkg::RST_PWM_PERIOD;
            r_hue_step_count    <= 8'd0;
            r_hue_angle         <= 8'd0;
            r_mode              <= rlf_pkg::MODE_HUE;
            r_breath_pwm_count  <= 8'd0;
            r_breath_step_count <= 8'd0;
            r_breath_duty       <= 8'd0;
            r_dwell_count       <= 4'd0;
            r_breath_rising     <= 1'b1;
            r_led_lit           <= 3'b000;
            r_button_held       <= 1'b0;
        end else if (in_fire) begin
            r_pwm_count         <= n_pwm_count;
            r_duty              <= n_duty;
            r_hue_step_count    <= n_hue_step_count;
            r_hue_angle         <= n_hue_angle;
            r_mode              <= n_mode;
            r_breath_pwm_count  <= n_breath_pwm_count;
            r_breath_step_count <= n_breath_step_count;
            r_breath_duty       <= n_breath_duty;
            r_dwell_count       <= n_dwell_count;
            r_breath_rising     <= n_breath_rising;
            r_led_lit           <= n_led_lit;
            r_button_held       <= n_button_held;
        end
    end

    always_comb begin
        result.green_on = n_led_lit[rlf_pkg::CH_GREEN];
        result.red_on   = n_led_lit[rlf_pkg::CH_RED];
        result.blue_on  = n_led_lit[rlf_pkg::CH_BLUE];
        result.mode     = n_mode;
    end

    rlf_pkg::t_result out_data;

    rlf_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_fire),
        .i_data  (result),
        .o_space (buf_space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (out_data)
    );

    assign o_green_on = out_data.green_on;
    assign o_red_on   = out_data.red_on;
    assign o_blue_on  = out_data.blue_on;
    assign o_mode     = out_data.mode;

endmodule

### rtl/core/rlf_out_buf.sv
// ----------------------------------------------------------------------------
// rlf_out_buf
// Output register with a skid stage, so requests keep flowing while a
// finished result waits downstream.
// ----------------------------------------------------------------------------
module rlf_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rlf_pkg::t_result i_data,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output rlf_pkg::t_result o_data
);

    logic             r_out_valid;
    logic             n_out_valid;
    rlf_pkg::t_result r_out_data;
    rlf_pkg::t_result n_out_data;
    logic             r_skid_valid;
    logic             n_skid_valid;
    rlf_pkg::t_result r_skid_data;
    rlf_pkg::t_result n_skid_data;
    logic             load_out;

    assign o_space  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out_data;
    assign load_out = !r_out_valid || i_ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (load_out) begin
            if (r_skid_valid) begin
                n_out_valid = 1'b1;
                n_out_data  = r_skid_data;
            end else begin
                n_out_valid = i_push;
                n_out_data  = i_data;
            end
            n_skid_valid = 1'b0;
        end else if (i_push) begin
            n_skid_valid = 1'b1;
            n_skid_data  = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

endmodule
